// ===== sv/hpt_pkg.sv =====
// Shared types and constants for the homogeneous point transform.
// Used by hpt_lane, hpt_merge, homogeneous_point_transform and the testbench; no dependencies.
`timescale 1ns / 1ps

package hpt_pkg;

  localparam int unsigned NUM_ROWS    = 4;
  localparam int unsigned NUM_COLS    = 4;
  localparam int unsigned ELEM_W      = 16;
  localparam int unsigned OUT_W       = 34;
  localparam int unsigned COORD_W_DEF = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = NUM_ROWS * ELEM_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COL0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd4;

  // Identity matrix after reset, one column per register
  localparam logic [CFG_DATA_W-1:0] COL0_RST = 64'h0000_0000_0000_0001;
  localparam logic [CFG_DATA_W-1:0] COL1_RST = 64'h0000_0000_0001_0000;
  localparam logic [CFG_DATA_W-1:0] COL2_RST = 64'h0000_0001_0000_0000;
  localparam logic [CFG_DATA_W-1:0] COL3_RST = 64'h0001_0000_0000_0000;

  // Stage load strobes from the pipeline control to the lanes
  typedef struct packed {
    logic load_prod;
    logic load_sum;
  } hpt_ctl_t;

endpackage

// ===== sv/homogeneous_point_transform.sv =====
// Top level: 4x4 (or 3x3) matrix times vector, four row lanes and an output stage.
// Depends on hpt_pkg, hpt_lane and hpt_merge.
//
//   channel   signals                          direction
//   in        in_valid_i/in_ready_o, x,y,z,w   item in
//   out       out_valid_o/out_ready_i, out_*   result out
//   cfg       cfg_we_i, cfg_index_i, cfg_wdata_i write only
//
// One item per cycle while the output is not stalled; registered stages are
// products, row sums and the output register. Each of the four lanes holds
// four multipliers, so all sixteen products of an item are formed together.
// A stage loads when it is empty or the stage after it moves on, so bubbles
// collapse and a stall at the output only backs up into full stages. Reset
// clears the stage valids, sets the matrix to identity and selects the 4x4 mode.
`timescale 1ns / 1ps

module homogeneous_point_transform #(
  parameter int unsigned COORD_WIDTH = hpt_pkg::COORD_W_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hpt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [hpt_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [COORD_WIDTH-1:0]       x_i,
  input  logic signed [COORD_WIDTH-1:0]       y_i,
  input  logic signed [COORD_WIDTH-1:0]       z_i,
  input  logic signed [COORD_WIDTH-1:0]       w_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [hpt_pkg::OUT_W-1:0]    out_x_o,
  output logic signed [hpt_pkg::OUT_W-1:0]    out_y_o,
  output logic signed [hpt_pkg::OUT_W-1:0]    out_z_o,
  output logic signed [hpt_pkg::OUT_W-1:0]    out_w_o
);
  import hpt_pkg::*;

  logic [CFG_DATA_W-1:0] col_q [NUM_COLS];
  logic                  mode_q;

  logic                  v1_q, v2_q, v3_q;
  logic                  v1_d, v2_d, v3_d;
  logic                  free1, free2, free3;
  logic                  load3;
  hpt_ctl_t              ctl;

  logic signed [COORD_WIDTH-1:0] vec [NUM_COLS];
  logic [CFG_DATA_W-1:0]         row [NUM_ROWS];
  logic [OUT_W-1:0]              sum [NUM_ROWS];

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q[0] <= COL0_RST;
      col_q[1] <= COL1_RST;
      col_q[2] <= COL2_RST;
      col_q[3] <= COL3_RST;
      mode_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_COL0: col_q[0] <= cfg_wdata_i;
        REG_COL1: col_q[1] <= cfg_wdata_i;
        REG_COL2: col_q[2] <= cfg_wdata_i;
        REG_COL3: col_q[3] <= cfg_wdata_i;
        REG_MODE: mode_q   <= cfg_wdata_i[0];
        default:  ;
      endcase
    end
  end

  // Pipeline control
  always_comb begin
    free3         = !v3_q || out_ready_i;
    free2         = !v2_q || free3;
    free1         = !v1_q || free2;
    ctl.load_prod = in_valid_i && free1;
    ctl.load_sum  = v1_q && free2;
    load3         = v2_q && free3;
    v1_d          = ctl.load_prod || (v1_q && !free2);
    v2_d          = ctl.load_sum  || (v2_q && !free3);
    v3_d          = load3         || (v3_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  assign in_ready_o  = free1;
  assign out_valid_o = v3_q;

  assign vec[0] = x_i;
  assign vec[1] = y_i;
  assign vec[2] = z_i;
  assign vec[3] = w_i;

  // Transpose: lane r gets row r, entry c taken from column c
  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        row[r][c*ELEM_W +: ELEM_W] = col_q[c][r*ELEM_W +: ELEM_W];
      end
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_lane
    hpt_lane #(
      .COORD_WIDTH(COORD_WIDTH)
    ) u_lane (
      .clk_i     (clk_i),
      .ctl_i     (ctl),
      .row_i     (row[r]),
      .col3_en_i (!mode_q),
      .vec_i     (vec),
      .sum_o     (sum[r])
    );
  end

  hpt_merge u_merge (
    .clk_i        (clk_i),
    .load_i       (load3),
    .plane_mode_i (mode_q),
    .sum_i        (sum),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .out_w_o      (out_w_o)
  );

endmodule

// ===== sv/hpt_lane.sv =====
// One matrix row: four registered multiplies, then a registered sum.
// Depends on hpt_pkg.
`timescale 1ns / 1ps

module hpt_lane #(
  parameter int unsigned COORD_WIDTH = hpt_pkg::COORD_W_DEF
) (
  input  logic                                          clk_i,
  input  hpt_pkg::hpt_ctl_t                             ctl_i,
  input  logic [hpt_pkg::CFG_DATA_W-1:0]                row_i,
  input  logic                                          col3_en_i,
  input  logic signed [COORD_WIDTH-1:0]                 vec_i [hpt_pkg::NUM_COLS],
  output logic [hpt_pkg::OUT_W-1:0]                     sum_o
);
  import hpt_pkg::*;

  localparam int unsigned PROD_W = ELEM_W + COORD_WIDTH;
  localparam int unsigned EXT_W  = (PROD_W > OUT_W) ? PROD_W : OUT_W;

  logic signed [PROD_W-1:0] prod_d [NUM_COLS];
  logic signed [PROD_W-1:0] prod_q [NUM_COLS];
  logic [OUT_W-1:0]         sum_d;
  logic [OUT_W-1:0]         sum_q;

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      prod_d[c] = $signed(row_i[c*ELEM_W +: ELEM_W]) * vec_i[c];
    end
    // 3x3 mode drops column 3
    if (!col3_en_i) begin
      prod_d[NUM_COLS-1] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_prod) begin
      prod_q <= prod_d;
    end
  end

  // Sum modulo 2^OUT_W: sign-extend each product, keep the low bits
  always_comb begin
    logic signed [EXT_W-1:0] ext;
    sum_d = '0;
    for (int c = 0; c < NUM_COLS; c++) begin
      ext   = EXT_W'(prod_q[c]);
      sum_d = sum_d + ext[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_sum) begin
      sum_q <= sum_d;
    end
  end

  assign sum_o = sum_q;

endmodule

// ===== sv/hpt_merge.sv =====
// Output stage: gathers the four row sums into the result register.
// Depends on hpt_pkg.
`timescale 1ns / 1ps

module hpt_merge (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic                         plane_mode_i,
  input  logic [hpt_pkg::OUT_W-1:0]    sum_i [hpt_pkg::NUM_ROWS],
  output logic signed [hpt_pkg::OUT_W-1:0] out_x_o,
  output logic signed [hpt_pkg::OUT_W-1:0] out_y_o,
  output logic signed [hpt_pkg::OUT_W-1:0] out_z_o,
  output logic signed [hpt_pkg::OUT_W-1:0] out_w_o
);
  import hpt_pkg::*;

  logic [OUT_W-1:0] res_d [NUM_ROWS];
  logic [OUT_W-1:0] res_q [NUM_ROWS];

  always_comb begin
    res_d = sum_i;
    // 2D mode has no row 3
    if (plane_mode_i) begin
      res_d[NUM_ROWS-1] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign out_x_o = $signed(res_q[0]);
  assign out_y_o = $signed(res_q[1]);
  assign out_z_o = $signed(res_q[2]);
  assign out_w_o = $signed(res_q[3]);

endmodule

// ===== tb/tb_homogeneous_point_transform.sv =====
// Self-checking testbench for homogeneous_point_transform: directed corner points, then
// random points under several matrix settings in both modes, with random idling on both sides.
// Depends on hpt_pkg and the homogeneous_point_transform RTL.
`timescale 1ns / 1ps

module tb_homogeneous_point_transform;
  import hpt_pkg::*;

  localparam int COORD_W        = COORD_W_DEF;
  localparam int RAND_PHASES    = 9;
  localparam int PHASE_POINTS   = 104;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic MODE_3D = 1'b0;
  localparam logic MODE_2D = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ELEM_W-1:0]  elem_t;
  typedef logic signed [OUT_W-1:0]   out_t;
  typedef logic [CFG_DATA_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  typedef enum int {MAT_ALL_MIN, MAT_ALL_MAX, MAT_RANDOM} matrix_kind_e;

  typedef struct {
    out_t out_x;
    out_t out_y;
    out_t out_z;
    out_t out_w;
  } point_result_t;

  localparam coord_t C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam coord_t C_MAX = {1'b0, {(COORD_W-1){1'b1}}};

  // Tracks the matrix and mode, transforms each accepted point and matches results in order.
  class transform_tracker;
    cfg_word_t     col [NUM_COLS];
    logic          flat_mode;
    point_result_t transformed_q[$];
    int unsigned   errors;
    int unsigned   checked;

    function new();
      col[0]    = COL0_RST;
      col[1]    = COL1_RST;
      col[2]    = COL2_RST;
      col[3]    = COL3_RST;
      flat_mode = MODE_3D;
      errors    = 0;
      checked   = 0;
    endfunction

    function void set_register(cfg_idx_t idx, cfg_word_t data);
      if (idx < REG_MODE) begin
        col[idx] = data;
      end else if (idx == REG_MODE) begin
        flat_mode = data[0];
      end
    endfunction

    function void note_point(coord_t px, coord_t py, coord_t pz, coord_t pw);
      longint        vec [NUM_COLS];
      longint        acc;
      out_t          sums [NUM_ROWS];
      int            n;
      point_result_t r;
      vec[0] = longint'(px);
      vec[1] = longint'(py);
      vec[2] = longint'(pz);
      vec[3] = longint'(pw);
      n = (flat_mode == MODE_2D) ? 3 : 4;
      for (int row = 0; row < NUM_ROWS; row++) begin
        acc = 0;
        if (row < n) begin
          for (int c = 0; c < n; c++) begin
            acc += longint'(elem_t'(col[c][row*ELEM_W +: ELEM_W])) * vec[c];
          end
        end
        sums[row] = acc[OUT_W-1:0];
      end
      r.out_x = sums[0];
      r.out_y = sums[1];
      r.out_z = sums[2];
      r.out_w = sums[3];
      transformed_q.push_back(r);
    endfunction

    function void compare(string field, out_t want, out_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_point(out_t ax, out_t ay, out_t az, out_t aw);
      point_result_t e;
      if (transformed_q.size() == 0) begin
        $error("result with no point pending: out_x %0d out_y %0d out_z %0d out_w %0d",
               ax, ay, az, aw);
        errors++;
        return;
      end
      e = transformed_q.pop_front();
      compare("out_x", e.out_x, ax);
      compare("out_y", e.out_y, ay);
      compare("out_z", e.out_z, az);
      compare("out_w", e.out_w, aw);
      checked++;
    endfunction

    function int pending();
      return transformed_q.size();
    endfunction
  endclass

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      cfg_we_i    = 1'b0;
  cfg_idx_t  cfg_index_i = REG_COL0;
  cfg_word_t cfg_wdata_i = '0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  coord_t    x_i         = '0;
  coord_t    y_i         = '0;
  coord_t    z_i         = '0;
  coord_t    w_i         = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_t      out_x_o;
  out_t      out_y_o;
  out_t      out_z_o;
  out_t      out_w_o;

  transform_tracker sb;
  bit          rx_hold_req = 1'b0;
  bit          rx_steady   = 1'b0;
  int unsigned cfg_loads   = 0;
  int unsigned stall_cycles = 0;

  homogeneous_point_transform #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_i        (x_i),
    .y_i        (y_i),
    .z_i        (z_i),
    .w_i        (w_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_x_o    (out_x_o),
    .out_y_o    (out_y_o),
    .out_z_o    (out_z_o),
    .out_w_o    (out_w_o)
  );

  always #5 clk_i = ~clk_i;

  // Handshakes are sampled before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_point(x_i, y_i, z_i, w_i);
      if (out_valid_o && out_ready_i) sb.check_point(out_x_o, out_y_o, out_z_o, out_w_o);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("tb_homogeneous_point_transform: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Result side: random stall bursts, one long hold-off on request, none once steady.
  initial begin : rx_drive
    int unsigned gap;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!rx_steady && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 15);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 7))
      0:       return C_MIN;
      1:       return C_MAX;
      2:       return '0;
      3:       return '1;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(ELEM_W-1){1'b0}}};
      1:       return {1'b0, {(ELEM_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return elem_t'($urandom);
    endcase
  endfunction

  task automatic send_point(input coord_t px, input coord_t py, input coord_t pz,
                            input coord_t pw);
    in_valid_i <= 1'b1;
    x_i        <= px;
    y_i        <= py;
    z_i        <= pz;
    w_i        <= pw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold off until every point has come back, then let the pipeline settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    // Let the monitor note the last accepted point first
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic cfg_write(input cfg_idx_t idx, input cfg_word_t data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_register(idx, data);
  endtask

  // Load all four columns and the mode (junk in the upper mode bits), plus one
  // write to an unused index that must change nothing.
  task automatic load_matrix(input matrix_kind_e kind, input logic mode);
    cfg_word_t column;
    cfg_word_t junk;
    for (int c = 0; c < NUM_COLS; c++) begin
      case (kind)
        MAT_ALL_MIN: column = {NUM_ROWS{1'b1, {(ELEM_W-1){1'b0}}}};
        MAT_ALL_MAX: column = {NUM_ROWS{1'b0, {(ELEM_W-1){1'b1}}}};
        default:     column = {rand_elem(), rand_elem(), rand_elem(), rand_elem()};
      endcase
      cfg_write(cfg_idx_t'(REG_COL0 + c), column);
    end
    junk = {$urandom, $urandom};
    cfg_write(REG_MODE, {junk[CFG_DATA_W-1:1], mode});
    cfg_write(cfg_idx_t'($urandom_range(REG_MODE + 1, (1 << CFG_IDX_W) - 1)),
              {$urandom, $urandom});
    cfg_we_i <= 1'b0;
    cfg_loads++;
  endtask

  initial begin : stimulus
    bit quiet;
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Identity matrix straight out of reset
    send_point('0, '0, '0, '0);
    send_point(C_MIN, C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MAX, coord_t'(-1), coord_t'(1));
    drain();

    // Largest positive sum and a deep negative one
    load_matrix(MAT_ALL_MIN, MODE_3D);
    send_point(C_MIN, C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MAX, C_MAX, C_MAX);
    send_point(coord_t'(1), coord_t'(-1), C_MIN, C_MAX);
    drain();

    load_matrix(MAT_ALL_MAX, MODE_3D);
    send_point(C_MIN, C_MIN, C_MIN, C_MIN);
    send_point(C_MAX, C_MAX, C_MAX, C_MAX);
    drain();

    // 2D: w and the fourth row and column must drop out, out_w stays zero
    load_matrix(MAT_RANDOM, MODE_2D);
    send_point(C_MIN, C_MAX, C_MIN, C_MAX);
    send_point(C_MAX, C_MIN, C_MAX, C_MIN);
    send_point(coord_t'(-1), coord_t'(-1), coord_t'(-1), coord_t'(-1));
    send_point('0, '0, '0, C_MAX);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      quiet = (ph == RAND_PHASES - 1);
      if (quiet) rx_steady = 1'b1;
      load_matrix(ph == 0 ? MAT_ALL_MAX : (ph == 1 ? MAT_ALL_MIN : MAT_RANDOM),
                  (ph % 2 == 1) ? MODE_2D : MODE_3D);
      for (int i = 0; i < PHASE_POINTS; i++) begin
        // Stall the result side for a long stretch while points keep coming
        if (ph == 2 && i == 20) rx_hold_req = 1'b1;
        if (!quiet && !rx_hold_req && ((i / 16) % 2 == 0) && $urandom_range(0, 3) == 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 15)) @(posedge clk_i);
        end
        send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end

    $display("Checked %0d transformed points over %0d matrix loads in 3D and 2D modes,",
             sb.checked, cfg_loads);
    $display("with corner coordinates, idle gaps on both sides and one long output stall.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_homogeneous_point_transform: clean");
    end else begin
      $display("tb_homogeneous_point_transform: errors");
    end
    $finish;
  end

endmodule
